// ===== rtl/rfsc_pkg.sv =====
// ----------------------------------------------------------------------------
// rfsc_pkg: shared types and constants for the rpn stack calculator
// Opcodes, status codes, controller states and the command/status structs
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package rfsc_pkg;

  localparam int unsigned QW    = 32;
  localparam int unsigned ModeW = 3;

  localparam logic [QW-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [QW-1:0] Q_MIN = 32'h8000_0000;

  typedef enum logic [ModeW-1:0] {
    MODE_PUSH  = 3'd0,
    MODE_ADD   = 3'd1,
    MODE_SUB   = 3'd2,
    MODE_MUL   = 3'd3,
    MODE_DIV   = 3'd4,
    MODE_CLEAR = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_SATURATED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_OPER,
    S_MULW,
    S_DIVW,
    S_FIN
  } state_e;

  typedef enum logic [1:0] {
    RES_ADDSUB,
    RES_MUL,
    RES_DIV
  } res_sel_e;

  typedef struct packed {
    logic     load;
    logic     clear;
    logic     halt;
    logic     push;
    logic     overflow;
    logic     underflow;
    logic     rd_second;
    logic     sub;
    logic     mul_capture;
    logic     div_start;
    logic     commit;
    res_sel_e res_sel;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic err;
    logic empty;
    logic one;
    logic full;
    logic div_done;
  } dp_stat_t;

endpackage

// ===== rtl/rpn_fixed_point_stack_calculator.sv =====
// one request in flight; the next is taken the cycle after its result registers
// push, clear, halted and underflow items go decode then result load; add/subtract
// add an operate step, multiply also a product step, and divide waits for the
// 48-step divider loop; result load waits while an earlier result is not taken
// reset clears stack count, error flag, sequencer and result valid; stack
// memory is not cleared, entries are written before they are read
// ----------------------------------------------------------------------------
// rpn_fixed_point_stack_calculator: reverse-polish Q16.16 stack machine
// Runs push/add/subtract/multiply/divide/clear instructions on an operand
// stack with saturation and a latched overflow/underflow error.
// ----------------------------------------------------------------------------
module rpn_fixed_point_stack_calculator #(
  parameter int unsigned STACK_DEPTH = 1024,
  localparam int unsigned CW    = $clog2(STACK_DEPTH + 1),
  localparam int unsigned OUT_W = ((rfsc_pkg::QW + CW + 3 + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [rfsc_pkg::QW-1:0]      s_axis_tdata,  // value
  input  logic [rfsc_pkg::ModeW-1:0]   s_axis_tuser,  // mode
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [OUT_W-1:0]             m_axis_tdata   // status, top_value, stack_depth, halted
);
  import rfsc_pkg::*;

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  status_e       out_status;
  logic [QW-1:0] out_top;
  logic [CW-1:0] out_depth;
  logic          out_halted;

  rfsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .mode_i      (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  rfsc_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .CW          (CW)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .value_i      (s_axis_tdata),
    .out_status_o (out_status),
    .out_top_o    (out_top),
    .out_depth_o  (out_depth),
    .out_halted_o (out_halted)
  );

  assign m_axis_tdata = OUT_W'({out_halted, out_depth, out_top, out_status});

endmodule

// ===== rtl/rfsc_div.sv =====
// ----------------------------------------------------------------------------
// rfsc_div: iterative Q16.16 divider
// Restoring radix-2 division of |a| * 2^16 by |b|, one quotient bit per
// cycle, then sign fix-up and saturation. A zero divisor saturates.
// ----------------------------------------------------------------------------
module rfsc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [rfsc_pkg::QW-1:0] a_i,
  input  logic signed [rfsc_pkg::QW-1:0] b_i,
  output logic                        done_o,
  output logic        [rfsc_pkg::QW-1:0] res_o,
  output logic                        sat_o
);
  import rfsc_pkg::*;

  localparam int unsigned QuoW   = QW + 16;
  localparam int unsigned CntW   = $clog2(QuoW);

  logic              busy_q, done_q;
  logic [CntW-1:0]   cnt_q;
  logic [QuoW-1:0]   dq_q;
  logic [QW-1:0]     rem_q, dv_q;
  logic              neg_q, zero_q, aneg_q;

  logic [QW-1:0]     a_mag, b_mag;
  logic [QW:0]       trial;
  logic [QW+1:0]     diff;
  logic              fits;

  assign a_mag = a_i[QW-1] ? QW'(-a_i) : QW'(a_i);
  assign b_mag = b_i[QW-1] ? QW'(-b_i) : QW'(b_i);
  assign trial = {rem_q, dq_q[QuoW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dv_q};
  assign fits  = ~diff[QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(QuoW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q   <= {a_mag, 16'h0000};
      rem_q  <= '0;
      dv_q   <= b_mag;
      neg_q  <= a_i[QW-1] ^ b_i[QW-1];
      aneg_q <= a_i[QW-1];
      zero_q <= (b_i == '0);
    end else if (busy_q) begin
      rem_q <= fits ? diff[QW-1:0] : trial[QW-1:0];
      dq_q  <= {dq_q[QuoW-2:0], fits};
    end
  end

  // clamp magnitude to the result sign's range; a zero divisor uses a's sign
  always_comb begin
    res_o = QW'(dq_q);
    sat_o = 1'b0;
    if (zero_q) begin
      sat_o = 1'b1;
      res_o = aneg_q ? Q_MIN : Q_MAX;
    end else if (neg_q) begin
      if ((|dq_q[QuoW-1:QW]) || (dq_q[QW-1] && (|dq_q[QW-2:0]))) begin
        sat_o = 1'b1;
        res_o = Q_MIN;
      end else begin
        res_o = ~dq_q[QW-1:0] + QW'(1);
      end
    end else if (|dq_q[QuoW-1:QW-1]) begin
      sat_o = 1'b1;
      res_o = Q_MAX;
    end
  end

  assign done_o = done_q;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (!busy_q && $past(busy_q)))
    else $error("divider done without a finished run");
`endif

endmodule

// ===== rtl/rfsc_datapath.sv =====
// ----------------------------------------------------------------------------
// rfsc_datapath: operand stack and arithmetic
// Top of stack in a register, deeper entries in a single-port-style memory,
// add/subtract/multiply with saturation, the divider and the result register.
// ----------------------------------------------------------------------------
module rfsc_datapath #(
  parameter int unsigned STACK_DEPTH = 1024,
  parameter int unsigned CW          = 11
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rfsc_pkg::dp_cmd_t              cmd_i,
  output rfsc_pkg::dp_stat_t             stat_o,
  input  logic signed [rfsc_pkg::QW-1:0] value_i,
  output rfsc_pkg::status_e              out_status_o,
  output logic        [rfsc_pkg::QW-1:0] out_top_o,
  output logic        [CW-1:0]           out_depth_o,
  output logic                           out_halted_o
);
  import rfsc_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic [QW-1:0]        mem [STACK_DEPTH];

  logic [CW-1:0]        count_q;
  logic                 err_q;
  logic signed [QW-1:0] top_q, value_q, rd_q;
  logic signed [2*QW-1:0] prod_q;
  status_e              st_q;
  logic                 halt_q;

  status_e              out_status_q;
  logic [QW-1:0]        out_top_q;
  logic [CW-1:0]        out_depth_q;
  logic                 out_halted_q;

  logic [CW-1:0]        idx_top, idx_second;
  logic signed [QW:0]   as_sum;
  logic [QW-1:0]        as_res, mul_res, div_res, res;
  logic                 as_sat, mul_sat, div_sat, sat, div_done;
  logic [QW+15:0]       mul_sh;

  assign idx_top    = count_q - CW'(1);
  assign idx_second = count_q - CW'(2);

  rfsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .a_i     (rd_q),
    .b_i     (top_q),
    .done_o  (div_done),
    .res_o   (div_res),
    .sat_o   (div_sat)
  );

  // add / subtract with one guard bit
  always_comb begin
    if (cmd_i.sub) begin
      as_sum = {rd_q[QW-1], rd_q} - {top_q[QW-1], top_q};
    end else begin
      as_sum = {rd_q[QW-1], rd_q} + {top_q[QW-1], top_q};
    end
    as_sat = as_sum[QW] ^ as_sum[QW-1];
    as_res = as_sat ? (as_sum[QW] ? Q_MIN : Q_MAX) : as_sum[QW-1:0];
  end

  // arithmetic shift of the product floors toward minus infinity
  always_comb begin
    mul_sh  = prod_q[2*QW-1:16];
    mul_sat = !((&mul_sh[QW+15:QW-1]) || !(|mul_sh[QW+15:QW-1]));
    mul_res = mul_sat ? (mul_sh[QW+15] ? Q_MIN : Q_MAX) : mul_sh[QW-1:0];
  end

  always_comb begin
    case (cmd_i.res_sel)
      RES_ADDSUB: begin
        res = as_res;
        sat = as_sat;
      end
      RES_MUL: begin
        res = mul_res;
        sat = mul_sat;
      end
      RES_DIV: begin
        res = div_res;
        sat = div_sat;
      end
      default: begin
        res = as_res;
        sat = as_sat;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      err_q   <= 1'b0;
    end else begin
      if (cmd_i.clear || cmd_i.underflow) begin
        count_q <= '0;
      end else if (cmd_i.push) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.commit) begin
        count_q <= idx_top;
      end
      if (cmd_i.clear) begin
        err_q <= 1'b0;
      end else if (cmd_i.overflow || cmd_i.underflow) begin
        err_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= value_i;
      st_q    <= ST_OK;
      halt_q  <= 1'b0;
    end
    if (cmd_i.halt) begin
      halt_q <= 1'b1;
    end
    if (cmd_i.overflow) begin
      st_q <= ST_OVERFLOW;
    end
    if (cmd_i.underflow) begin
      st_q <= ST_UNDERFLOW;
    end
    if (cmd_i.push) begin
      top_q <= value_q;
    end
    if (cmd_i.mul_capture) begin
      prod_q <= (2*QW)'(rd_q) * (2*QW)'(top_q);
    end
    if (cmd_i.commit) begin
      top_q <= res;
      st_q  <= sat ? ST_SATURATED : ST_OK;
    end
    if (cmd_i.out_load) begin
      out_status_q <= st_q;
      out_top_q    <= (count_q != '0) ? top_q : '0;
      out_depth_q  <= count_q;
      out_halted_q <= halt_q;
    end
  end

  // old top spills into the memory on a push
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && (count_q != '0)) begin
      mem[idx_top[AW-1:0]] <= top_q;
    end
    if (cmd_i.rd_second) begin
      rd_q <= mem[idx_second[AW-1:0]];
    end
  end

  assign stat_o.err      = err_q;
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.one      = (count_q == CW'(1));
  assign stat_o.full     = (count_q == CW'(STACK_DEPTH));
  assign stat_o.div_done = div_done;

  assign out_status_o = out_status_q;
  assign out_top_o    = out_top_q;
  assign out_depth_o  = out_depth_q;
  assign out_halted_o = out_halted_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (!err_q && (count_q == '0)))
    else $error("clear left stack or error behind");
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (count_q != CW'(STACK_DEPTH)))
    else $error("push onto a full stack");
`endif

endmodule

// ===== rtl/rfsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rfsc_ctrl: instruction sequencer
// Accepts one request at a time, decodes it against the stack status and
// steps the datapath through read, operate, commit and result load.
// ----------------------------------------------------------------------------
module rfsc_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [rfsc_pkg::ModeW-1:0]      mode_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output rfsc_pkg::dp_cmd_t               cmd_o,
  input  rfsc_pkg::dp_stat_t              stat_i
);
  import rfsc_pkg::*;

  state_e state_q, state_d;
  mode_e  mode_q;
  logic   ovalid_q;
  logic   accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_e'(mode_i);
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.res_sel = RES_ADDSUB;
    cmd_o.sub     = (mode_q == MODE_SUB);
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FIN;
        if (mode_q == MODE_CLEAR) begin
          cmd_o.clear = 1'b1;
        end else if (stat_i.err) begin
          cmd_o.halt = 1'b1;
        end else begin
          case (mode_q)
            MODE_PUSH: begin
              if (stat_i.full) begin
                cmd_o.overflow = 1'b1;
              end else begin
                cmd_o.push = 1'b1;
              end
            end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
              if (stat_i.empty || stat_i.one) begin
                cmd_o.underflow = 1'b1;
              end else begin
                cmd_o.rd_second = 1'b1;
                state_d         = S_OPER;
              end
            end
            default: ;
          endcase
        end
      end
      S_OPER: begin
        case (mode_q)
          MODE_MUL: begin
            cmd_o.mul_capture = 1'b1;
            state_d           = S_MULW;
          end
          MODE_DIV: begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIVW;
          end
          default: begin
            cmd_o.commit  = 1'b1;
            cmd_o.res_sel = RES_ADDSUB;
            state_d       = S_FIN;
          end
        endcase
      end
      S_MULW: begin
        cmd_o.commit  = 1'b1;
        cmd_o.res_sel = RES_MUL;
        state_d       = S_FIN;
      end
      S_DIVW: begin
        if (stat_i.div_done) begin
          cmd_o.commit  = 1'b1;
          cmd_o.res_sel = RES_DIV;
          state_d       = S_FIN;
        end
      end
      S_FIN: begin
        // result register must be free or draining this cycle
        if (!ovalid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!ovalid_q || out_ready_i))
    else $error("pending result overwritten");
  a_div_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> (state_q == S_DIVW))
    else $error("divider started outside the divide path");
  a_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_DECODE))
    else $error("accepted request not decoded");
`endif

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: stream-level bench for the rpn Q16.16 stack calculator
// Drives instruction requests from a queue, predicts every result with its own
// stack model and compares status, top, depth and halted flag in order.
// ----------------------------------------------------------------------------
module tb_top;
  import rfsc_pkg::*;

  localparam int unsigned STACK_DEPTH = 1024;
  localparam int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned RES_W       = ((QW + DEPTH_W + 3 + 7) / 8) * 8;
  localparam int unsigned N_ITEMS     = 1120;
  localparam int unsigned HOLD_AT     = 400;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_AT    = 900;
  localparam int unsigned TIMEOUT_CYC = 800000;

  localparam logic [ModeW-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [ModeW-1:0] MODE_SPARE_HI = 3'd7;

  localparam longint Q_HI = 64'sd2147483647;
  localparam longint Q_LO = -64'sd2147483648;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [QW-1:0]    value;
  } calc_req_t;

  typedef struct packed {
    status_e              status;
    logic [QW-1:0]        top;
    logic [DEPTH_W-1:0]   depth;
    logic                 halted;
  } calc_res_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [QW-1:0]       s_axis_tdata  = '0;
  logic [ModeW-1:0]    s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [RES_W-1:0]    m_axis_tdata;

  calc_req_t   req_q[$];
  calc_res_t   exp_res_q[$];
  int unsigned n_req_total;
  int unsigned n_accepted;
  int unsigned n_fail;
  int unsigned n_results;
  int unsigned n_sat, n_ovf, n_udf, n_halt;
  int unsigned max_depth_seen;
  int unsigned rx_hold_left;
  logic        rx_hold_done;

  // predictor state
  logic [QW-1:0] calc_stack [STACK_DEPTH];
  int unsigned   calc_depth;
  logic          calc_err;

  rpn_fixed_point_stack_calculator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  function automatic longint sat_q(longint v, ref logic sat);
    if (v > Q_HI) begin
      sat = 1'b1;
      return Q_HI;
    end
    if (v < Q_LO) begin
      sat = 1'b1;
      return Q_LO;
    end
    return v;
  endfunction

  function automatic calc_res_t calc_step(calc_req_t rq);
    calc_res_t r;
    longint    a, b, p;
    logic      sat;
    r.status = ST_OK;
    r.halted = 1'b0;
    sat      = 1'b0;
    if (rq.mode == MODE_CLEAR) begin
      calc_depth = 0;
      calc_err   = 1'b0;
    end else if (calc_err) begin
      r.halted = 1'b1;
    end else if (rq.mode == MODE_PUSH) begin
      if (calc_depth >= STACK_DEPTH) begin
        r.status = ST_OVERFLOW;
        calc_err = 1'b1;
      end else begin
        calc_stack[calc_depth] = rq.value;
        calc_depth++;
      end
    end else if (rq.mode inside {[MODE_ADD:MODE_DIV]}) begin
      if (calc_depth < 2) begin
        // lone operand is popped, stack ends empty
        calc_depth = 0;
        r.status   = ST_UNDERFLOW;
        calc_err   = 1'b1;
      end else begin
        b = longint'($signed(calc_stack[calc_depth-1]));
        a = longint'($signed(calc_stack[calc_depth-2]));
        case (rq.mode)
          MODE_ADD: p = sat_q(a + b, sat);
          MODE_SUB: p = sat_q(a - b, sat);
          MODE_MUL: p = sat_q((a * b) >>> 16, sat);
          default: begin
            if (b == 0) begin
              sat = 1'b1;
              p   = (a < 0) ? Q_LO : Q_HI;
            end else begin
              p = sat_q((a * 65536) / b, sat);
            end
          end
        endcase
        calc_depth--;
        calc_stack[calc_depth-1] = p[QW-1:0];
        if (sat) r.status = ST_SATURATED;
      end
    end
    r.top   = (calc_depth > 0) ? calc_stack[calc_depth-1] : '0;
    r.depth = calc_depth[DEPTH_W-1:0];
    return r;
  endfunction

  function automatic int unsigned tx_idle_pct();
    if (n_accepted * 3 < n_req_total) return 25;
    if (n_accepted * 3 < n_req_total * 2) return 54;
    return 0;
  endfunction

  function automatic int unsigned rx_idle_pct();
    if (n_accepted * 3 < n_req_total) return 54;
    if (n_accepted * 3 < n_req_total * 2) return 25;
    return 0;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    logic offer;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        exp_res_q.insert(exp_res_q.size(), calc_step(req_q[0]));
        void'(req_q.pop_front());
        n_accepted++;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        offer = (req_q.size() != 0) && ($urandom_range(99) >= tx_idle_pct());
        // one pause that waits until the block has drained
        if (n_accepted == DRAIN_AT && exp_res_q.size() != 0) offer = 1'b0;
        if (offer) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= req_q[0].value;
          s_axis_tuser  <= req_q[0].mode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted on its own
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_hold_left <= 0;
      rx_hold_done <= 1'b0;
    end else if (!rx_hold_done && n_accepted >= HOLD_AT) begin
      rx_hold_left <= HOLD_CYCLES;
      rx_hold_done <= 1'b1;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    calc_res_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = status_e'(m_axis_tdata[1:0]);
        got.top    = m_axis_tdata[QW+1:2];
        got.depth  = m_axis_tdata[QW+DEPTH_W+1:QW+2];
        got.halted = m_axis_tdata[QW+DEPTH_W+2];
        n_results++;
        if (got.status == ST_SATURATED) n_sat++;
        if (got.status == ST_OVERFLOW) n_ovf++;
        if (got.status == ST_UNDERFLOW) n_udf++;
        if (got.halted) n_halt++;
        if (32'(got.depth) > max_depth_seen) max_depth_seen = 32'(got.depth);
        if (exp_res_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) $display("unexpected result %h with nothing pending", m_axis_tdata);
        end else begin
          want = exp_res_q.pop_front();
          if (got.status != want.status || got.top != want.top ||
              got.depth != want.depth || got.halted != want.halted) begin
            n_fail++;
            if (n_fail <= 10)
              $display("mismatch at result %0d: exp st=%0d top=%h dep=%0d hlt=%0b,",
                       n_results, want.status, want.top, want.depth, want.halted,
                       " got st=%0d top=%h dep=%0d hlt=%0b",
                       got.status, got.top, got.depth, got.halted);
          end
        end
      end
      m_axis_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_idle_pct());
    end
  end

  task automatic add_req(logic [ModeW-1:0] mode, logic [QW-1:0] value);
    calc_req_t rq;
    rq.mode  = mode;
    rq.value = value;
    req_q.insert(req_q.size(), rq);
  endtask

  function automatic logic [QW-1:0] pick_q();
    logic [QW-1:0] v;
    case ($urandom_range(9))
      0: v = Q_MAX;
      1: v = Q_MIN;
      2: v = '0;
      3: v = $urandom_range(32'h0003_FFFF);
      4, 5: v = $urandom_range(32'h00FF_FFFF);
      default: v = $urandom;
    endcase
    if ($urandom_range(1) && v != Q_MIN) v = -v;
    return v;
  endfunction

  function automatic logic [ModeW-1:0] pick_op();
    return ModeW'(MODE_ADD + $urandom_range(3));
  endfunction

  initial begin
    int unsigned run_len, d;
    n_fail = 0; n_results = 0; n_accepted = 0;
    n_sat = 0; n_ovf = 0; n_udf = 0; n_halt = 0; max_depth_seen = 0;
    calc_depth = 0;
    calc_err   = 1'b0;
    n_req_total = 0;

    // saturation corners, rounding, divide by zero, spare selectors, errors
    add_req(MODE_CLEAR, '0);
    add_req(MODE_PUSH, Q_MAX);
    add_req(MODE_PUSH, 32'h0000_0001);
    add_req(MODE_ADD, '0);
    add_req(MODE_PUSH, Q_MIN);
    add_req(MODE_PUSH, 32'h0001_0000);
    add_req(MODE_SUB, '0);
    add_req(MODE_PUSH, Q_MAX);
    add_req(MODE_MUL, '0);
    add_req(MODE_PUSH, 32'h0001_8000);
    add_req(MODE_PUSH, 32'hFFFF_8001);
    add_req(MODE_MUL, '0);
    add_req(MODE_PUSH, '0);
    add_req(MODE_DIV, '0);
    add_req(MODE_PUSH, '0);
    add_req(MODE_PUSH, '0);
    add_req(MODE_DIV, '0);
    add_req(MODE_PUSH, 32'h0003_0000);
    add_req(MODE_PUSH, 32'hFFFE_0000);
    add_req(MODE_DIV, 32'hFFFF_FFFF);
    add_req(MODE_SPARE_LO, 32'hFFFF_FFFF);
    add_req(MODE_SPARE_HI, '0);
    add_req(MODE_CLEAR, 32'hFFFF_FFFF);
    add_req(MODE_ADD, '0);
    add_req(MODE_PUSH, 32'h1234_5678);
    add_req(MODE_CLEAR, '0);
    add_req(MODE_PUSH, 32'h0005_0000);
    add_req(MODE_DIV, '0);
    add_req(MODE_SPARE_HI, '0);

    // one run that fills the stack and overflows it
    add_req(MODE_CLEAR, '0);
    d = 0;
    while (d < STACK_DEPTH) begin
      if (d >= 2 && $urandom_range(99) < 1) begin
        add_req(pick_op(), $urandom);
        d--;
      end else begin
        add_req(MODE_PUSH, pick_q());
        d++;
      end
    end
    add_req(MODE_PUSH, pick_q());
    add_req(MODE_MUL, '0);
    add_req(MODE_SPARE_LO, '0);

    // short runs, mostly well formed, some noise
    while (req_q.size() < N_ITEMS) begin
      if ($urandom_range(9) != 0) add_req(MODE_CLEAR, $urandom);
      run_len = $urandom_range(1, 24);
      if ($urandom_range(9) < 8) begin
        d = 0;
        repeat (run_len) begin
          if ($urandom_range(99) < 4) begin
            add_req($urandom_range(0, 1) ? MODE_SPARE_LO : MODE_SPARE_HI, $urandom);
          end else if (d < 2 || $urandom_range(99) < 50) begin
            add_req(MODE_PUSH, pick_q());
            d++;
          end else begin
            add_req(pick_op(), $urandom);
            d--;
          end
        end
      end else begin
        repeat (run_len) add_req(ModeW'($urandom_range(7)), pick_q());
      end
    end
    n_req_total = req_q.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() != 0 || exp_res_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("ran %0d requests: %0d saturated, %0d overflow, %0d underflow, %0d halted",
             n_results, n_sat, n_ovf, n_udf, n_halt);
    $display("deepest stack %0d, %0d mismatches", max_depth_seen, n_fail);
    if (n_fail == 0 && exp_res_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    repeat (TIMEOUT_CYC) @(posedge clk_i);
    $display("timeout with %0d requests still queued", req_q.size());
    $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rfsc_pkg.sv
rtl/rfsc_div.sv
rtl/rfsc_datapath.sv
rtl/rfsc_ctrl.sv
rtl/rpn_fixed_point_stack_calculator.sv
bench/tb_top.sv
